FILE: sv/smeu_pkg.sv
// Package for the stack machine execute unit: opcodes, error codes, sizes,
// controller states and the controller-to-datapath command struct.
// No dependencies.
`timescale 1ns / 1ps
package smeu_pkg;

    localparam int StackDepth = 64;
    localparam int MemBytes = 65536;
    localparam int ProgDepth = 65536;
    localparam int SpW = $clog2(StackDepth);
    localparam int DepthW = $clog2(StackDepth + 1);
    localparam int MemAw = $clog2(MemBytes);
    localparam int IpW = $clog2(ProgDepth);
    localparam logic [63:0] ExitSyscall = 64'd60;
    localparam logic [15:0] MemBaseReset = 16'd32768;

    // Opcodes.
    localparam logic [4:0] OP_PUSH = 5'd0;
    localparam logic [4:0] OP_DUP = 5'd1;
    localparam logic [4:0] OP_DROP = 5'd2;
    localparam logic [4:0] OP_SWAP = 5'd3;
    localparam logic [4:0] OP_OVER = 5'd4;
    localparam logic [4:0] OP_PRINT = 5'd5;
    localparam logic [4:0] OP_ADD = 5'd6;
    localparam logic [4:0] OP_SUB = 5'd7;
    localparam logic [4:0] OP_MUL = 5'd8;
    localparam logic [4:0] OP_DIVMOD = 5'd9;
    localparam logic [4:0] OP_EQ = 5'd10;
    localparam logic [4:0] OP_LT = 5'd11;
    localparam logic [4:0] OP_LE = 5'd12;
    localparam logic [4:0] OP_GT = 5'd13;
    localparam logic [4:0] OP_GE = 5'd14;
    localparam logic [4:0] OP_SHR = 5'd15;
    localparam logic [4:0] OP_SHL = 5'd16;
    localparam logic [4:0] OP_OR = 5'd17;
    localparam logic [4:0] OP_AND = 5'd18;
    localparam logic [4:0] OP_IF = 5'd19;
    localparam logic [4:0] OP_ELSE = 5'd20;
    localparam logic [4:0] OP_END = 5'd21;
    localparam logic [4:0] OP_WHILE = 5'd22;
    localparam logic [4:0] OP_DO = 5'd23;
    localparam logic [4:0] OP_MEM = 5'd24;
    localparam logic [4:0] OP_LOAD = 5'd25;
    localparam logic [4:0] OP_STORE = 5'd26;
    localparam logic [4:0] OP_SYSCALL = 5'd27;

    // Error codes.
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER = 3'd2;
    localparam logic [2:0] ERR_DIV0 = 3'd3;
    localparam logic [2:0] ERR_ADDR = 3'd4;
    localparam logic [2:0] ERR_SYS = 3'd5;

    // Controller states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_EXEC = 3'd3;
    localparam logic [2:0] ST_DIV = 3'd4;
    localparam logic [2:0] ST_FIN = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear_step;   // write zero to the memory sweep address
        logic load_req;     // capture the request
        logic read_ops;     // read the top two stack entries
        logic exec;         // check and execute the request
        logic div_start;    // start the divider
        logic div_finish;   // push quotient and remainder
    } smeu_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic div_go;       // exec decided a divide is needed
        logic div_done;
    } smeu_stat_t;

    // Operands required per opcode.
    function automatic logic [1:0] need_f(input logic [4:0] op);
        logic [1:0] n;
        case (op)
            OP_PUSH, OP_ELSE, OP_END, OP_WHILE, OP_MEM: n = 2'd0;
            OP_DUP, OP_DROP, OP_PRINT, OP_IF, OP_DO, OP_LOAD: n = 2'd1;
            OP_SWAP, OP_OVER, OP_ADD, OP_SUB, OP_MUL, OP_DIVMOD, OP_EQ, OP_LT,
            OP_LE, OP_GT, OP_GE, OP_SHR, OP_SHL, OP_OR, OP_AND, OP_STORE,
            OP_SYSCALL: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // Results pushed per opcode.
    function automatic logic [1:0] give_f(input logic [4:0] op);
        logic [1:0] g;
        case (op)
            OP_DUP, OP_SWAP, OP_DIVMOD: g = 2'd2;
            OP_OVER: g = 2'd3;
            OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE,
            OP_SHR, OP_SHL, OP_OR, OP_AND, OP_MEM, OP_LOAD: g = 2'd1;
            default: g = 2'd0;
        endcase
        return g;
    endfunction

endpackage

FILE: sv/smeu_divider.sv
// Radix-2 restoring divider for signed 64-bit truncating divmod.
// Depends on smeu_pkg.
`timescale 1ns / 1ps
module smeu_divider
    import smeu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic        qneg_reg, qneg_next, rneg_reg, rneg_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    assign trial = {r_reg, q_reg[63]} - {1'b0, d_reg};

    // One quotient bit per cycle over magnitudes.
    always_comb begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = 7'd0;
            q_next = dividend[63] ? 64'd0 - dividend : dividend;
            d_next = divisor[63] ? 64'd0 - divisor : divisor;
            r_next = 64'd0;
            qneg_next = dividend[63] ^ divisor[63];
            rneg_next = dividend[63];
        end else if (busy_reg) begin
            if (!trial[64]) begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done = done_reg;
    assign quotient = qneg_reg ? 64'd0 - q_reg : q_reg;
    assign remainder = rneg_reg ? 64'd0 - r_reg : r_reg;

endmodule

FILE: sv/smeu_datapath.sv
// Datapath: data stack, byte memory, ALU, error checks and result register.
// Depends on smeu_pkg and smeu_divider.
`timescale 1ns / 1ps
module smeu_datapath
    import smeu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  smeu_cmd_t   cmd,
    output smeu_stat_t  stat,
    input  logic [15:0] user_mem_base,
    input  logic [84:0] req_data,
    output logic [92:0] res_data
);

    logic [63:0]      stack_mem [StackDepth];
    logic [7:0]       byte_mem [MemBytes];
    logic [DepthW-1:0] depth_reg, depth_next;
    logic [IpW-1:0]   ip_reg, ip_next;
    logic             halt_reg, halt_next;
    logic [MemAw-1:0] clr_reg;
    logic             clr_done_reg;
    logic [4:0]       op_reg;
    logic [63:0]      imm_reg;
    logic [15:0]      tgt_reg;
    logic [63:0]      y_reg, x_reg;
    logic [7:0]       rd_byte_reg;
    logic             ld_pend_reg;
    logic             mul_pend_reg;
    logic [63:0]      mul_ll_reg;
    logic [31:0]      mul_cross_reg;
    logic             div_go_reg;
    logic [92:0]      res_reg, res_next;

    logic [SpW-1:0] top_idx, sec_idx;
    assign top_idx = SpW'(depth_reg - DepthW'(1));
    assign sec_idx = SpW'(depth_reg - DepthW'(2));

    // Error checks, in priority order.
    logic [2:0] err;
    logic [1:0] need, give;
    logic [DepthW+1:0] new_depth;
    always_comb begin
        need = need_f(op_reg);
        give = give_f(op_reg);
        new_depth = (DepthW+2)'(depth_reg) - (DepthW+2)'(need) + (DepthW+2)'(give);
        err = ERR_NONE;
        if (op_reg > OP_SYSCALL)
            err = ERR_SYS;
        else if (depth_reg < DepthW'(need))
            err = ERR_UNDER;
        else if (new_depth > (DepthW+2)'(StackDepth))
            err = ERR_OVER;
        else if (op_reg == OP_DIVMOD && y_reg == 64'd0)
            err = ERR_DIV0;
        else if (op_reg == OP_LOAD && y_reg >= 64'(MemBytes))
            err = ERR_ADDR;
        else if (op_reg == OP_STORE && x_reg >= 64'(MemBytes))
            err = ERR_ADDR;
        else if (op_reg == OP_SYSCALL && y_reg != ExitSyscall)
            err = ERR_SYS;
    end

    // The request runs only when the machine is live and no check fails.
    logic exec_ok;
    assign exec_ok = cmd.exec && !halt_reg && (err == ERR_NONE);

    // Byte memory: clearing sweep, store writes, load reads.
    always_ff @(posedge aclk) begin
        if (cmd.clear_step)
            byte_mem[clr_reg] <= 8'd0;
        else if (exec_ok && op_reg == OP_STORE)
            byte_mem[x_reg[MemAw-1:0]] <= y_reg[7:0];
        rd_byte_reg <= byte_mem[y_reg[MemAw-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (cmd.clear_step) begin
            clr_reg <= clr_reg + MemAw'(1);
            if (clr_reg == MemAw'(MemBytes - 1))
                clr_done_reg <= 1'b1;
        end
    end

    // ALU result for single-result ops other than multiply and load.
    logic [63:0] alu;
    logic lt_xy, lt_yx;
    assign lt_xy = $signed(x_reg) < $signed(y_reg);
    assign lt_yx = $signed(y_reg) < $signed(x_reg);
    always_comb begin
        case (op_reg)
            OP_PUSH: alu = imm_reg;
            OP_ADD: alu = x_reg + y_reg;
            OP_SUB: alu = x_reg - y_reg;
            OP_EQ: alu = {63'd0, x_reg == y_reg};
            OP_LT: alu = {63'd0, lt_xy};
            OP_LE: alu = {63'd0, !lt_yx};
            OP_GT: alu = {63'd0, lt_yx};
            OP_GE: alu = {63'd0, !lt_xy};
            OP_SHR: alu = $unsigned($signed(x_reg) >>> y_reg[5:0]);
            OP_SHL: alu = x_reg << y_reg[5:0];
            OP_OR: alu = x_reg | y_reg;
            OP_AND: alu = x_reg & y_reg;
            OP_MEM: alu = {48'd0, user_mem_base};
            default: alu = 64'd0;
        endcase
    end

    // Multiply partial products, captured in the check cycle. Only the low
    // 64 bits of the product are kept, so the high-by-high term drops out.
    always_ff @(posedge aclk) begin
        mul_ll_reg <= {32'd0, x_reg[31:0]} * {32'd0, y_reg[31:0]};
        mul_cross_reg <= x_reg[31:0] * y_reg[63:32] + x_reg[63:32] * y_reg[31:0];
    end

    // Divider.
    logic        div_done;
    logic [63:0] quo, rem;
    smeu_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(x_reg), .divisor(y_reg),
        .done(div_done), .quotient(quo), .remainder(rem)
    );

    logic [IpW-1:0] ip_inc;
    logic [IpW-1:0] ip_tgt;
    assign ip_inc = ip_reg + IpW'(1);
    assign ip_tgt = IpW'(tgt_reg);
    logic [DepthW-1:0] base;
    assign base = DepthW'(depth_reg - DepthW'(need));

    // Next machine state and result for the check step and the divide finish.
    always_comb begin
        res_next = {ERR_NONE, 8'd0, 1'b0, 64'd0, 1'b0, 16'(ip_inc)};
        depth_next = depth_reg;
        ip_next = ip_reg;
        halt_next = halt_reg;
        if (cmd.div_finish) begin
            ip_next = ip_inc;
        end else if (halt_reg) begin
            res_next = {ERR_NONE, 8'd0, 1'b1, 64'd0, 1'b0, 16'(ip_reg)};
        end else if (err != ERR_NONE) begin
            halt_next = 1'b1;
            res_next = {err, 8'd0, 1'b1, 64'd0, 1'b0, 16'(ip_reg)};
        end else begin
            depth_next = DepthW'(new_depth);
            ip_next = ip_inc;
            case (op_reg)
                OP_PRINT:
                    res_next = {ERR_NONE, 8'd0, 1'b0, y_reg, 1'b1, 16'(ip_inc)};
                OP_DIVMOD: begin
                    // The index moves when the divider finishes; the depth stays, as divmod pops two and pushes two.
                    depth_next = depth_reg;
                    ip_next = ip_reg;
                end
                OP_IF, OP_DO: if (y_reg == 64'd0) begin
                    ip_next = ip_tgt;
                    res_next = {ERR_NONE, 8'd0, 1'b0, 64'd0, 1'b0, 16'(ip_tgt)};
                end
                OP_ELSE, OP_END: begin
                    ip_next = ip_tgt;
                    res_next = {ERR_NONE, 8'd0, 1'b0, 64'd0, 1'b0, 16'(ip_tgt)};
                end
                OP_SYSCALL: begin
                    halt_next = 1'b1;
                    ip_next = ip_reg;
                    res_next = {ERR_NONE, x_reg[7:0], 1'b1, 64'd0, 1'b0, 16'(ip_reg)};
                end
                default: ;
            endcase
        end
    end

    // Machine state registers and pending-write flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            ip_reg <= '0;
            halt_reg <= 1'b0;
            div_go_reg <= 1'b0;
            ld_pend_reg <= 1'b0;
            mul_pend_reg <= 1'b0;
        end else begin
            div_go_reg <= exec_ok && (op_reg == OP_DIVMOD);
            ld_pend_reg <= exec_ok && (op_reg == OP_LOAD);
            mul_pend_reg <= exec_ok && (op_reg == OP_MUL);
            if (cmd.exec || cmd.div_finish) begin
                depth_reg <= depth_next;
                ip_reg <= ip_next;
                halt_reg <= halt_next;
            end
        end
    end

    // Request capture, operand reads and result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg <= req_data[4:0];
            imm_reg <= req_data[68:5];
            tgt_reg <= req_data[84:69];
        end
        if (cmd.read_ops) begin
            y_reg <= stack_mem[top_idx];
            x_reg <= stack_mem[sec_idx];
        end
        if (cmd.exec || cmd.div_finish)
            res_reg <= res_next;
    end

    // Stack writes: the check step, then load, multiply or divide results.
    always_ff @(posedge aclk) begin
        if (exec_ok) begin
            case (op_reg)
                OP_DUP: begin
                    stack_mem[SpW'(base)] <= y_reg;
                    stack_mem[SpW'(base + DepthW'(1))] <= y_reg;
                end
                OP_SWAP: begin
                    stack_mem[SpW'(base)] <= y_reg;
                    stack_mem[SpW'(base + DepthW'(1))] <= x_reg;
                end
                OP_OVER: begin
                    stack_mem[SpW'(base)] <= x_reg;
                    stack_mem[SpW'(base + DepthW'(1))] <= y_reg;
                    stack_mem[SpW'(base + DepthW'(2))] <= x_reg;
                end
                OP_PUSH, OP_ADD, OP_SUB, OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE,
                OP_SHR, OP_SHL, OP_OR, OP_AND, OP_MEM:
                    stack_mem[SpW'(base)] <= alu;
                default: ;
            endcase
        end else if (ld_pend_reg) begin
            // Load data is written in the cycle after the check.
            stack_mem[top_idx] <= {56'd0, rd_byte_reg};
        end else if (mul_pend_reg) begin
            // The depth already counts the product as the new top.
            stack_mem[top_idx] <= mul_ll_reg + {mul_cross_reg, 32'd0};
        end else if (cmd.div_finish) begin
            stack_mem[sec_idx] <= quo;
            stack_mem[top_idx] <= rem;
        end
    end

    assign stat.clear_done = clr_done_reg;
    assign stat.div_go = div_go_reg;
    assign stat.div_done = div_done;
    assign res_data = res_reg;

endmodule

FILE: sv/smeu_ctrl.sv
// Controller state machine: memory clearing, request sequencing, divide wait
// and result handshake. Depends on smeu_pkg.
`timescale 1ns / 1ps
module smeu_ctrl
    import smeu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  smeu_stat_t stat,
    output smeu_cmd_t  cmd
);

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = !stat.clear_done;
                if (stat.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load_req = s_tvalid;
                if (s_tvalid) state_next = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.read_ops = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // Also lets a load's data land before the result goes out.
                if (stat.div_go) cmd.div_start = 1'b1;
                else state_next = ST_OUT;
                if (stat.div_go) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (stat.div_done) begin
                    cmd.div_finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else state_reg <= state_next;
    end

endmodule

FILE: sv/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit.
// Depends on smeu_pkg, smeu_ctrl and smeu_datapath.
//
//  channel | ports            | payload
//  input   | s_tvalid/s_tready| s_tdata: req_type, imm_value, jump_target
//  result  | m_tvalid/m_tready| m_tdata: next_ip .. fault code
//  config  | user_mem_base_we | user_mem_base_wdata
//
// An item passes from request to result through the accept, read, check,
// settle and result steps; multiply and load finish their stack write in
// the settle step. Divmod adds a wait for its one-bit-per-cycle divider.
// After reset a sweep clears the 65536-byte memory, one byte per cycle,
// before the first request is accepted. One request is in flight at a time;
// a stalled result holds until taken.
`timescale 1ns / 1ps
module stack_machine_execute_unit
    import smeu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // req_type[4:0], imm_value[68:5], jump_target[84:69]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // next_ip, print_valid, print_value, halted,
                                  // exit_code, fault code
    input  logic        user_mem_base_we,
    input  logic [15:0] user_mem_base_wdata
);

    smeu_cmd_t   cmd;
    smeu_stat_t  stat;
    logic [15:0] base_reg;
    logic [92:0] res;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) base_reg <= MemBaseReset;
        else if (user_mem_base_we) base_reg <= user_mem_base_wdata;
    end

    smeu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    smeu_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .user_mem_base(base_reg), .req_data(s_tdata[84:0]), .res_data(res)
    );

    assign m_tdata = {3'd0, res};

endmodule
